/* hdl/qi_packet_biphase_serializer_macros.svh */
// Assertion macros for the Qi packet bi-phase serializer checker.
// Expects a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef QI_PACKET_BIPHASE_SERIALIZER_MACROS_SVH
`define QI_PACKET_BIPHASE_SERIALIZER_MACROS_SVH

// Property checked only while reset is released.
`define QPBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define QPBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/qpbs_pkg.sv */
// Shared types, constants and functions of the Qi packet bi-phase serializer.
// Used by the controller, the datapath and the top level; no dependencies.
package qpbs_pkg;

    // One input item: a packet byte plus its framing marks.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [4:0] pre_delay_ms;
        logic [4:0] preamble_count;
    } t_in_item;

    // One result item: eight half-bit line levels plus run marks.
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last_of_run;
        logic       message_end;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DELAY,
        ST_PRE,
        ST_DATA,
        ST_CHECK,
        ST_PAD,
        ST_FLUSH
    } t_state;

    // Source of the half-bit produced in a cycle.
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_DELAY,
        SRC_PRE,
        SRC_WORD,
        SRC_PAD
    } t_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture an accepted item
        logic load_word;   // load the 11-bit word shifter
        logic word_csum;   // word source: checksum instead of data byte
        t_src src;         // half-bit source this cycle
        logic flush;       // push the held byte as the final one of the run
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first;       // captured item is a header byte
        logic last;        // captured item closes the packet
        logic delay_zero;  // no pre-delay requested
        logic pre_zero;    // no preamble requested
        logic step;        // a half-bit can be taken this cycle
        logic seg_end;     // the current half-bit ends its segment
        logic end_ok;      // aligned with the line high: no padding needed
        logic can_push;    // the output register can take a byte
    } t_status;

    // Half-bits in one coded 11-bit word, minus one.
    localparam logic [6:0] WORD_LAST_HALF = 7'd21;
    localparam logic [2:0] FILL_TOP = 3'd7;

    // Frame a byte: start 0, data LSB first, odd parity, stop 1.
    // Bit 10 is sent first.
    function automatic logic [10:0] word_of(input logic [7:0] b);
        logic [7:0] rev;
        for (int i = 0; i < 8; i++) begin
            rev[7 - i] = b[i];
        end
        return {1'b0, rev, ~(^b), 1'b1};
    endfunction

endpackage

/* hdl/qi_packet_biphase_serializer.sv */
// Top level of the Qi packet bi-phase serializer.
// Depends on qpbs_pkg, qpbs_ctrl and qpbs_datapath.
//
// Input channel: one packet byte per item with first/last marks and, on the
// header, the pre-delay and preamble lengths. Output channel: packed bytes of
// eight half-bit line levels, earliest half-bit in bit 7, for an SPI shifter.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// One item at a time: after acceptance the input stalls until the final output
// byte of that item has entered the output register. The half-bit packer makes
// one half-bit per cycle while no full byte waits on a stalled output. An item
// codes 22 half-bits, plus 4*pre_delay_ms + 2*preamble_count on a header and
// 22 + up to 8 when it closes a packet. Each item yields 2 to 30 output bytes.
// The newest completed byte is held back one step so it can carry the
// last_of_run and message_end marks. When the receiver stalls, packing stops at
// the next completed byte until the output register frees up; nothing is lost.
// Reset (synchronous, active low) empties both stages, sets the line level low,
// clears the checksum and starts packing at the most significant bit.
module qi_packet_biphase_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  qpbs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qpbs_pkg::t_out_item o_out_data
);

    qpbs_pkg::t_cmd    w_cmd;
    qpbs_pkg::t_status w_status;

    // Sequencing of the delay, preamble, word, checksum and padding phases.
    qpbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Coding, packing and output register.
    qpbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/qpbs_ctrl.sv */
// Sequencing controller of the Qi packet bi-phase serializer.
// Depends on qpbs_pkg; drives commands to qpbs_datapath.
module qpbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  qpbs_pkg::t_status i_status,
    output qpbs_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    qpbs_pkg::t_state r_state;
    qpbs_pkg::t_state n_state;
    logic             w_seg_done;

    // A segment finishes when its final half-bit is taken.
    assign w_seg_done = i_status.step && i_status.seg_end;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qpbs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = qpbs_pkg::ST_DISPATCH;
            end
            qpbs_pkg::ST_DISPATCH: begin
                if (i_status.first && !i_status.delay_zero) begin
                    n_state = qpbs_pkg::ST_DELAY;
                end else if (i_status.first && !i_status.pre_zero) begin
                    n_state = qpbs_pkg::ST_PRE;
                end else begin
                    n_state = qpbs_pkg::ST_DATA;
                end
            end
            qpbs_pkg::ST_DELAY: begin
                if (w_seg_done) begin
                    n_state = i_status.pre_zero ? qpbs_pkg::ST_DATA : qpbs_pkg::ST_PRE;
                end
            end
            qpbs_pkg::ST_PRE: begin
                if (w_seg_done) n_state = qpbs_pkg::ST_DATA;
            end
            qpbs_pkg::ST_DATA: begin
                if (w_seg_done) begin
                    n_state = i_status.last ? qpbs_pkg::ST_CHECK : qpbs_pkg::ST_FLUSH;
                end
            end
            qpbs_pkg::ST_CHECK: begin
                if (w_seg_done) n_state = qpbs_pkg::ST_PAD;
            end
            qpbs_pkg::ST_PAD: begin
                if (i_status.end_ok || w_seg_done) n_state = qpbs_pkg::ST_FLUSH;
            end
            qpbs_pkg::ST_FLUSH: begin
                if (i_status.can_push) n_state = qpbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_cmd.src  = qpbs_pkg::SRC_NONE;
        o_in_stall = 1'b1;
        unique case (r_state)
            qpbs_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            qpbs_pkg::ST_DISPATCH: begin
                o_cmd.load_word = 1'b1;
            end
            qpbs_pkg::ST_DELAY: begin
                o_cmd.src = qpbs_pkg::SRC_DELAY;
            end
            qpbs_pkg::ST_PRE: begin
                o_cmd.src = qpbs_pkg::SRC_PRE;
            end
            qpbs_pkg::ST_DATA: begin
                // The checksum word follows the data word without a gap.
                o_cmd.src       = qpbs_pkg::SRC_WORD;
                o_cmd.load_word = w_seg_done && i_status.last;
                o_cmd.word_csum = 1'b1;
            end
            qpbs_pkg::ST_CHECK: begin
                o_cmd.src = qpbs_pkg::SRC_WORD;
            end
            qpbs_pkg::ST_PAD: begin
                o_cmd.src = i_status.end_ok ? qpbs_pkg::SRC_NONE : qpbs_pkg::SRC_PAD;
            end
            qpbs_pkg::ST_FLUSH: begin
                o_cmd.flush = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/qpbs_datapath.sv */
// Datapath of the Qi packet bi-phase serializer: half-bit coder, byte packer,
// held byte and output register. Depends on qpbs_pkg; driven by qpbs_ctrl.
module qpbs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qpbs_pkg::t_in_item  i_in_data,
    input  qpbs_pkg::t_cmd      i_cmd,
    input  logic                i_out_stall,
    output qpbs_pkg::t_status   o_status,
    output logic                o_out_valid,
    output qpbs_pkg::t_out_item o_out_data
);

    // Captured item (payload, no reset).
    qpbs_pkg::t_in_item  r_item;
    // Coding state.
    logic [7:0]          r_partial, n_partial;
    logic [2:0]          r_fill, n_fill;
    logic                r_line, n_line;
    logic [7:0]          r_csum, n_csum;
    logic [6:0]          r_cnt, n_cnt;
    logic [10:0]         r_word, n_word;
    // Last completed byte, waiting to learn whether it ends the run.
    logic [7:0]          r_held, n_held;
    logic                r_held_v, n_held_v;
    // Output register.
    logic                r_out_v, n_out_v;
    qpbs_pkg::t_out_item r_out, n_out;

    logic w_hb;
    logic w_seg_end;
    logic w_can_push;
    logic w_step;
    logic w_emit;

    // A completed byte needs room only when an older one is still held.
    assign w_can_push = !r_out_v || !i_out_stall;
    assign w_step     = !((r_fill == 3'd0) && r_held_v && !w_can_push);
    assign w_emit     = (i_cmd.src != qpbs_pkg::SRC_NONE) && w_step;

    // Half-bit level and segment end for the active source.
    always_comb begin
        w_hb      = 1'b0;
        w_seg_end = 1'b0;
        case (i_cmd.src)
            qpbs_pkg::SRC_DELAY: begin
                // Four high half-bits per millisecond.
                w_hb      = 1'b1;
                w_seg_end = (r_cnt == ({r_item.pre_delay_ms, 2'b00} - 7'd1));
            end
            qpbs_pkg::SRC_PRE: begin
                w_hb      = ~r_cnt[0];
                w_seg_end = (r_cnt == ({1'b0, r_item.preamble_count, 1'b0} - 7'd1));
            end
            qpbs_pkg::SRC_WORD: begin
                // First half always flips; a one flips again at mid-bit.
                w_hb      = (r_cnt[0] && r_word[10]) ? r_line : ~r_line;
                w_seg_end = (r_cnt == qpbs_pkg::WORD_LAST_HALF);
            end
            qpbs_pkg::SRC_PAD: begin
                w_hb      = 1'b1;
                w_seg_end = (r_fill == 3'd0);
            end
            default: begin
                w_hb      = 1'b0;
                w_seg_end = 1'b0;
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.first      = r_item.first_byte;
        o_status.last       = r_item.last_byte;
        o_status.delay_zero = (r_item.pre_delay_ms == 5'd0);
        o_status.pre_zero   = (r_item.preamble_count == 5'd0);
        o_status.step       = w_step;
        o_status.seg_end    = w_seg_end;
        o_status.end_ok     = (r_fill == qpbs_pkg::FILL_TOP) && r_line;
        o_status.can_push   = w_can_push;
    end

    // Next values of the coding state and the output side.
    always_comb begin
        n_partial = r_partial;
        n_fill    = r_fill;
        n_line    = r_line;
        n_csum    = r_csum;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_out_v   = r_out_v;
        n_out     = r_out;

        // A waiting byte leaves when the receiver does not stall.
        if (!i_out_stall) n_out_v = 1'b0;

        // A header restarts the checksum and the line level.
        if (i_cmd.load) begin
            if (i_in_data.first_byte) begin
                n_csum = i_in_data.data_byte;
                n_line = 1'b0;
            end else begin
                n_csum = r_csum ^ i_in_data.data_byte;
            end
        end

        if (w_emit) begin
            n_cnt = w_seg_end ? 7'd0 : r_cnt + 7'd1;
            // Word bit finished: shift, and a zero bit leaves the line flipped.
            if ((i_cmd.src == qpbs_pkg::SRC_WORD) && r_cnt[0]) begin
                n_word = {r_word[9:0], 1'b0};
                if (!r_word[10]) n_line = ~r_line;
            end
            // Pack the half-bit; a full byte moves to the hold stage.
            if (r_fill == 3'd0) begin
                if (r_held_v) begin
                    n_out_v             = 1'b1;
                    n_out.spi_byte      = r_held;
                    n_out.last_of_run   = 1'b0;
                    n_out.message_end   = 1'b0;
                end
                n_held    = r_partial | {7'd0, w_hb};
                n_held_v  = 1'b1;
                n_partial = 8'd0;
                n_fill    = qpbs_pkg::FILL_TOP;
            end else begin
                n_partial[r_fill] = w_hb;
                n_fill            = r_fill - 3'd1;
            end
        end

        if (i_cmd.load_word) begin
            n_word = qpbs_pkg::word_of(i_cmd.word_csum ? r_csum : r_item.data_byte);
        end

        // The held byte closes the run; a packet end leaves the line high.
        if (i_cmd.flush && w_can_push) begin
            n_out_v           = 1'b1;
            n_out.spi_byte    = r_held;
            n_out.last_of_run = 1'b1;
            n_out.message_end = r_item.last_byte;
            n_held_v          = 1'b0;
            if (r_item.last_byte) begin
                n_line = 1'b1;
                n_csum = 8'd0;
            end
        end
    end

    // Control and coding state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 8'd0;
            r_fill    <= qpbs_pkg::FILL_TOP;
            r_line    <= 1'b0;
            r_csum    <= 8'd0;
            r_cnt     <= 7'd0;
            r_held_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_fill    <= n_fill;
            r_line    <= n_line;
            r_csum    <= n_csum;
            r_cnt     <= n_cnt;
            r_held_v  <= n_held_v;
            r_out_v   <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_data;
        r_word <= n_word;
        r_held <= n_held;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

/* hdl/qpbs_checker.sv */
// Port-level checker for the Qi packet bi-phase serializer, bound to the top.
// Depends on qpbs_pkg and qi_packet_biphase_serializer_macros.svh.
`include "qi_packet_biphase_serializer_macros.svh"

module qpbs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input qpbs_pkg::t_out_item o_out_data
);

    // A stalled output item keeps its value.
    `QPBS_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "output item changed while stalled")

    // An accepted item blocks the input until its run is out.
    `QPBS_ASSERT(a_one_item, i_in_valid && !o_in_stall |=> o_in_stall, "input not stalled after an item was accepted")

    // A packet end only ever marks the final byte of a run.
    `QPBS_ASSERT(a_end_is_last, o_out_valid && o_out_data.message_end |-> o_out_data.last_of_run, "message end on a byte that is not the last of its run")

    // While a run's earlier bytes are leaving, the block is still busy.
    `QPBS_ASSERT(a_run_busy, o_out_valid && !o_out_data.last_of_run |-> o_in_stall, "input open while a run is unfinished")

    // Reset empties the output register.
    `QPBS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind qi_packet_biphase_serializer qpbs_checker u_qpbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
